// File: hw/rtl/lpsc_pkg.sv
package lpsc_pkg;

    // Unit status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Prefix size limits and reset value
    localparam logic [2:0] PREFIX_MIN   = 3'd1;
    localparam logic [2:0] PREFIX_MAX   = 3'd4;
    localparam logic [2:0] PREFIX_RESET = 3'd4;

    // Start code 00 00 00 01, entry 0 goes out first
    localparam int START_LEN = 4;
    localparam logic [START_LEN-1:0][7:0] START_CODE = {8'h01, 8'h00, 8'h00, 8'h00};

    // Counts start code bytes already sent, 0..START_LEN
    typedef logic [2:0] start_idx_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       unit_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       unit_end;
        logic [1:0] status;
    } out_t;

    // One classified input byte, as handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       start;
        logic       unit_end;
        logic [1:0] status;
    } cmd_t;

endpackage

// File: hw/rtl/lpsc_front.sv
module lpsc_front #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  prefix_we,
    input  logic [2:0]            prefix_wdata,
    input  logic                  item_valid,
    input  lpsc_pkg::in_t         item,
    output logic                  cmd_push,
    output lpsc_pkg::cmd_t        cmd
);

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'b01,
        PH_PAYLOAD = 2'b10
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             prefix_reg;
    logic [2:0]             count_reg, count_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic                   first_reg, first_next;
    logic [1:0]             err_reg, err_next;
    logic [2:0]             eff_prefix;
    logic [2:0]             count_inc;
    logic [LENGTH_BITS+7:0] rem_grown;
    logic [LENGTH_BITS-1:0] rem_shift;
    logic [LENGTH_BITS-1:0] rem_dec;

    always_comb
    begin
        if (prefix_reg < lpsc_pkg::PREFIX_MIN)
        begin
            eff_prefix = lpsc_pkg::PREFIX_MIN;
        end
        else if (prefix_reg > lpsc_pkg::PREFIX_MAX)
        begin
            eff_prefix = lpsc_pkg::PREFIX_MAX;
        end
        else
        begin
            eff_prefix = prefix_reg;
        end
    end

    // length shift saturates once the top byte is in use
    assign rem_grown = {rem_reg, item.in_byte};
    assign rem_shift = (rem_grown[LENGTH_BITS+7 -: 8] != 8'd0) ? '1
                     : rem_grown[LENGTH_BITS-1:0];
    assign rem_dec   = (rem_reg != '0) ? rem_reg - LENGTH_BITS'(1) : rem_reg;
    assign count_inc = count_reg + 3'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        first_next   = first_reg;
        err_next     = err_reg;
        cmd.data     = item.in_byte;
        cmd.has_data = 1'b0;
        cmd.start    = 1'b0;
        cmd.unit_end = item.unit_last;
        cmd.status   = lpsc_pkg::ST_OK;

        if (err_reg == lpsc_pkg::ST_OK)
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    rem_next = rem_shift;
                    if (count_inc >= eff_prefix)
                    begin
                        count_next = 3'd0;
                        if (rem_shift == '0)
                        begin
                            err_next = lpsc_pkg::ST_ZERO;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                            first_next = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                    if (item.unit_last && err_next == lpsc_pkg::ST_OK)
                    begin
                        err_next = lpsc_pkg::ST_TRUNC;
                    end
                end
                PH_PAYLOAD:
                begin
                    cmd.has_data = 1'b1;
                    cmd.start    = first_reg;
                    first_next   = 1'b0;
                    rem_next     = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_PREFIX;
                        count_next = 3'd0;
                    end
                    else if (item.unit_last)
                    begin
                        err_next = lpsc_pkg::ST_TRUNC;
                    end
                end
                default:
                begin
                    phase_next = PH_PREFIX;
                end
            endcase
        end

        if (item.unit_last)
        begin
            cmd.status = err_next;
            phase_next = PH_PREFIX;
            count_next = 3'd0;
            rem_next   = '0;
            first_next = 1'b0;
            err_next   = lpsc_pkg::ST_OK;
        end
    end

    // bytes that yield nothing (prefix, dropped) are not queued
    assign cmd_push = item_valid && (cmd.has_data || item.unit_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= lpsc_pkg::PREFIX_RESET;
            phase_reg  <= PH_PREFIX;
            count_reg  <= 3'd0;
            rem_reg    <= '0;
            first_reg  <= 1'b0;
            err_reg    <= lpsc_pkg::ST_OK;
        end
        else
        begin
            if (prefix_we)
            begin
                prefix_reg <= prefix_wdata;
            end
            if (item_valid)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                rem_reg   <= rem_next;
                first_reg <= first_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// File: hw/rtl/lpsc_fifo.sv
module lpsc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  lpsc_pkg::cmd_t wr_data,
    input  logic           rd_en,
    output lpsc_pkg::cmd_t rd_data,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpsc_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fifo count above depth");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en)
        else $error("command written into full fifo");
`endif

endmodule

// File: hw/rtl/lpsc_back.sv
module lpsc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  lpsc_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           pop,
    output logic           empty,
    output lpsc_pkg::out_t out_item
);

    lpsc_pkg::start_idx_t idx_reg, idx_next;
    logic                 in_start;
    logic                 take;

    assign in_start = cmd.start && (idx_reg < lpsc_pkg::start_idx_t'(lpsc_pkg::START_LEN));
    assign empty    = cmd_empty;
    assign take     = pop && !cmd_empty;
    assign cmd_pop  = take && !in_start;

    always_comb
    begin
        if (in_start)
        begin
            out_item.out_byte   = lpsc_pkg::START_CODE[idx_reg[1:0]];
            out_item.byte_valid = 1'b1;
            out_item.unit_end   = 1'b0;
            out_item.status     = lpsc_pkg::ST_OK;
        end
        else
        begin
            out_item.out_byte   = cmd.has_data ? cmd.data : 8'd0;
            out_item.byte_valid = cmd.has_data;
            out_item.unit_end   = cmd.unit_end;
            out_item.status     = cmd.unit_end ? cmd.status : lpsc_pkg::ST_OK;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = in_start ? idx_reg + lpsc_pkg::start_idx_t'(1) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (!cmd_empty && cmd.start))
        else $error("start code index set without a start command at head");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= lpsc_pkg::start_idx_t'(lpsc_pkg::START_LEN))
        else $error("start code index past end");
`endif

endmodule

// File: hw/rtl/length_prefixed_to_start_code_nal_top.sv
// Length-prefixed NAL units in, start-code NAL units out.
// Input queue side: an in_item transfer happens when push is high and full is
// low; one byte of the access unit per transfer, unit_last on its final byte.
// Output queue side: out_item holds the oldest result while empty is low and
// is a transfer when pop is high. A NAL payload's first byte is preceded by
// 00 00 00 01; prefix bytes and bytes after an error produce nothing, except
// that the final byte always produces a result with unit_end and status.
// prefix_we/prefix_wdata set the prefix size (reset 4); change it when idle.
// A result's command is registered in the queue; out_item reads the queue head.
// Throughput: one input byte per cycle while full is low; the output side moves
// one result per cycle while pop is high, so each start code's four extra results
// are absorbed by the QUEUE_DEPTH-entry command queue ahead of the output sequencer.
// full rises only when that queue is full, so a stalled receiver backs up
// into full after QUEUE_DEPTH queued commands. Reset clears parser state,
// the queue and the start code counter; no clearing pass.
module length_prefixed_to_start_code_nal_top #(
    parameter int LENGTH_BITS = 32,  // length accumulator width, 8..32
    parameter int QUEUE_DEPTH = 4    // command queue entries, >= 2
) (
    input  logic           clk,
    input  logic           rst_n,
    // configuration
    input  logic           prefix_we,
    input  logic [2:0]     prefix_wdata,
    // input queue side
    input  logic           push,
    output logic           full,
    input  lpsc_pkg::in_t  in_item,
    // output queue side
    input  logic           pop,
    output logic           empty,
    output lpsc_pkg::out_t out_item
);

    logic           item_valid;
    logic           cmd_push;
    logic           cmd_pop;
    logic           cmd_empty;
    lpsc_pkg::cmd_t cmd_in;
    lpsc_pkg::cmd_t cmd_head;

    assign item_valid = push && !full;

    // parser: strips length prefixes, tracks errors, classifies each byte
    lpsc_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .prefix_we    (prefix_we),
        .prefix_wdata (prefix_wdata),
        .item_valid   (item_valid),
        .item         (in_item),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    // decouples parser from the output sequencer
    lpsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .full    (full),
        .empty   (cmd_empty)
    );

    // expands start commands into four start code results, then the byte
    lpsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

endmodule

// File: test/length_prefixed_to_start_code_nal_top_test.sv
module length_prefixed_to_start_code_nal_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Must match the DUT defaults
    localparam int LEN_BITS    = 32;
    localparam int QUEUE_DEPTH = 4;

    // Saturation value of the length accumulator, widened by one byte
    localparam logic [LEN_BITS+7:0] LEN_CAP = {{8{1'b0}}, {LEN_BITS{1'b1}}};

    // Cycles allowed after the last expected result before touching the register.
    // A prefix byte or a dropped byte makes no result but may still be in flight.
    localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;

    // Cycles without any transfer on either side before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;

    localparam int PHASES      = 9;
    localparam int PHASE_BYTES = 38;
    localparam int DIR_ROWS    = 31;

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'b01,
        PH_PAYLOAD = 2'b10
    } parse_phase_t;

    typedef enum logic {
        ROW_ITEM   = 1'b0,
        ROW_PREFIX = 1'b1
    } row_kind_t;

    // One row of the directed stimulus: either a register write or one byte.
    // Where typed is set, want is the single result that byte must produce.
    typedef struct packed {
        row_kind_t      kind;
        logic [2:0]     prefix;
        lpsc_pkg::in_t  item;
        logic           typed;
        lpsc_pkg::out_t want;
    } directed_row_t;

    // ------------------------------------------------------------------
    // DUT signals, all known from time zero
    // ------------------------------------------------------------------
    logic           clk;
    logic           rst_n        = 1'b0;
    logic           prefix_we    = 1'b0;
    logic [2:0]     prefix_wdata = '0;
    logic           push         = 1'b0;
    logic           full;
    lpsc_pkg::in_t  in_item      = '0;
    logic           pop          = 1'b0;
    logic           empty;
    lpsc_pkg::out_t out_item;

    length_prefixed_to_start_code_nal_top #(
        .LENGTH_BITS (LEN_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .prefix_we    (prefix_we),
        .prefix_wdata (prefix_wdata),
        .push         (push),
        .full         (full),
        .in_item      (in_item),
        .pop          (pop),
        .empty        (empty),
        .out_item     (out_item)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Converter model: register copy and per-unit parse state
    // ------------------------------------------------------------------
    logic [2:0]          cfg_prefix;
    parse_phase_t        parse_phase;
    logic [2:0]          len_bytes_seen;
    logic [LEN_BITS-1:0] len_left;
    logic                start_pending;
    logic [1:0]          unit_error;

    lpsc_pkg::out_t fresh_results [$];   // results of the byte just modeled
    lpsc_pkg::out_t annexb_due [$];      // results still owed by the DUT, oldest first
    lpsc_pkg::in_t  unit_bytes [$];      // one random access unit being built

    int send_idle_pct = 38;
    int recv_idle_pct = 56;
    int calm_left     = 0;

    int mismatch_count = 0;
    int bytes_in       = 0;
    int results_out    = 0;
    int units_seen     = 0;
    int units_bad      = 0;
    int quiet_cycles   = 0;

    directed_row_t directed_rows [DIR_ROWS];
    int            phase_prefix  [PHASES] = '{5, 1, 3, 6, 2, 4, 1, 4, 0};

    // 0 behaves as 1, 5..7 behave as 4
    function automatic logic [2:0] active_prefix();
        if (cfg_prefix < lpsc_pkg::PREFIX_MIN)
            return lpsc_pkg::PREFIX_MIN;
        if (cfg_prefix > lpsc_pkg::PREFIX_MAX)
            return lpsc_pkg::PREFIX_MAX;
        return cfg_prefix;
    endfunction

    function automatic logic [7:0] start_code_byte(input int idx);
        return (idx == 3) ? 8'h01 : 8'h00;
    endfunction

    function automatic void clear_unit();
        parse_phase    = PH_LENGTH;
        len_bytes_seen = '0;
        len_left       = '0;
        start_pending  = 1'b0;
        unit_error     = lpsc_pkg::ST_OK;
    endfunction

    // Models one accepted byte; leaves its results in fresh_results
    function automatic void convert_byte(input lpsc_pkg::in_t it);
        logic [LEN_BITS+7:0] grown;
        logic                emitted;
        lpsc_pkg::out_t      r;
        fresh_results.delete();
        emitted = 1'b0;
        if (unit_error == lpsc_pkg::ST_OK)
        begin
            if (parse_phase == PH_LENGTH)
            begin
                // big-endian accumulate, pinned at the accumulator maximum
                grown = {len_left, it.in_byte};
                if (grown > LEN_CAP)
                    grown = LEN_CAP;
                len_left       = grown[LEN_BITS-1:0];
                len_bytes_seen = len_bytes_seen + 3'd1;
                if (len_bytes_seen >= active_prefix())
                begin
                    len_bytes_seen = '0;
                    if (len_left == '0)
                        unit_error = lpsc_pkg::ST_ZERO;
                    else
                    begin
                        parse_phase   = PH_PAYLOAD;
                        start_pending = 1'b1;
                    end
                end
                // unit ending on a length byte is truncated unless already failed
                if (it.unit_last && unit_error == lpsc_pkg::ST_OK)
                    unit_error = lpsc_pkg::ST_TRUNC;
            end
            else
            begin
                if (start_pending)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        r = '{start_code_byte(i), 1'b1, 1'b0, lpsc_pkg::ST_OK};
                        fresh_results.push_back(r);
                    end
                    start_pending = 1'b0;
                end
                r = '{it.in_byte, 1'b1, 1'b0, lpsc_pkg::ST_OK};
                fresh_results.push_back(r);
                emitted = 1'b1;
                if (len_left != '0)
                    len_left = len_left - 1'b1;
                if (len_left == '0)
                begin
                    parse_phase    = PH_LENGTH;
                    len_bytes_seen = '0;
                end
                else if (it.unit_last)
                    unit_error = lpsc_pkg::ST_TRUNC;
            end
        end
        if (it.unit_last)
        begin
            // status rides on the payload byte if there is one, else alone
            if (emitted)
            begin
                r = fresh_results.pop_back();
                r.unit_end = 1'b1;
                r.status   = unit_error;
            end
            else
                r = '{8'h00, 1'b0, 1'b1, unit_error};
            fresh_results.push_back(r);
            clear_unit();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers; all of them start and end at a falling edge
    // ------------------------------------------------------------------

    // Random stretches where neither side idles
    always @(posedge clk)
    begin
        if (calm_left > 0)
            calm_left <= calm_left - 1;
        else if ($urandom_range(0, 199) == 0)
            calm_left <= $urandom_range(16, 48);
    end

    // One byte transfer; the expectation is queued once the DUT takes it
    task automatic send_item(input lpsc_pkg::in_t it, input logic typed,
                             input lpsc_pkg::out_t want);
        while (send_idle_pct != 0 && calm_left == 0 &&
               $urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (full);
        bytes_in++;
        convert_byte(it);
        if (typed)
            annexb_due.push_back(want);
        else
            foreach (fresh_results[i])
                annexb_due.push_back(fresh_results[i]);
        @(negedge clk);
    endtask

    // Wait for every owed result, then let in-flight silent bytes settle
    task automatic wait_quiet();
        push <= 1'b0;
        while (annexb_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_prefix(input logic [2:0] value);
        prefix_we    <= 1'b1;
        prefix_wdata <= value;
        @(negedge clk);
        prefix_we    <= 1'b0;
        cfg_prefix    = value;
    endtask

    function automatic void add_unit_byte(input int value);
        lpsc_pkg::in_t b;
        b.in_byte   = value[7:0];
        b.unit_last = 1'b0;
        unit_bytes.push_back(b);
    endfunction

    // Builds one access unit: mostly well formed NALs with random payload,
    // some with a zero length, some cut short, and a few of pure noise.
    task automatic build_unit();
        int            flavor;
        int            nals;
        int            zero_at;
        int            len;
        int            cut;
        int            psize;
        lpsc_pkg::in_t b;
        unit_bytes.delete();
        flavor = $urandom_range(0, 99);
        psize  = active_prefix();
        if (flavor < 6)
        begin
            repeat ($urandom_range(1, 8))
                add_unit_byte($urandom_range(0, 255));
        end
        else
        begin
            nals    = $urandom_range(1, 3);
            zero_at = (flavor < 14) ? $urandom_range(0, nals - 1) : -1;
            for (int n = 0; n < nals; n++)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 6);
                if (n == zero_at)
                    len = 0;
                for (int i = psize - 1; i >= 0; i--)
                    add_unit_byte((len >> (8 * i)) & 8'hff);
                repeat (len)
                    add_unit_byte($urandom_range(0, 255));
            end
            if (flavor >= 14 && flavor < 26 && unit_bytes.size() > 1)
            begin
                cut = $urandom_range(1, unit_bytes.size() - 1);
                while (unit_bytes.size() > cut)
                    unit_bytes.delete(unit_bytes.size() - 1);
            end
        end
        b = unit_bytes.pop_back();
        b.unit_last = 1'b1;
        unit_bytes.push_back(b);
    endtask

    // ------------------------------------------------------------------
    // Result side: random pop, compare against the oldest expectation
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (recv_idle_pct == 0 || calm_left > 0)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void check_field(input string name, input int unsigned expected,
                                        input int unsigned actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expected, actual);
            mismatch_count++;
        end
    endfunction

    lpsc_pkg::out_t oldest_due;

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            results_out++;
            if (annexb_due.size() == 0)
            begin
                $error("unexpected result transfer: byte 0x%0h valid %0b end %0b status %0d",
                       out_item.out_byte, out_item.byte_valid, out_item.unit_end,
                       out_item.status);
                mismatch_count++;
            end
            else
            begin
                oldest_due = annexb_due.pop_front();
                check_field("out_byte", oldest_due.out_byte, out_item.out_byte);
                check_field("byte_valid", oldest_due.byte_valid, out_item.byte_valid);
                check_field("unit_end", oldest_due.unit_end, out_item.unit_end);
                check_field("status", oldest_due.status, out_item.status);
                if (out_item.unit_end)
                begin
                    units_seen++;
                    if (out_item.status != lpsc_pkg::ST_OK)
                        units_bad++;
                end
            end
        end
    end

    // Hang detector: any transfer on either side restarts the count
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results still owed",
                     QUIET_LIMIT, annexb_due.size());
            $display("length_prefixed_to_start_code_nal_top_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int sent;

        directed_rows = '{
            // reset size 4: an all-zero length closed by the last byte
            '{ROW_ITEM,   3'd0, '{8'h00, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h00, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h00, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h00, 1'b1}, 1'b1,
              '{8'h00, 1'b0, 1'b1, lpsc_pkg::ST_ZERO}},
            // one length byte, two NALs in one unit
            '{ROW_PREFIX, 3'd1, '0,             1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h01, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'hab, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h01, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'hcd, 1'b1}, 1'b0, '0},
            // unit ends inside a payload: last byte still goes out, truncated
            '{ROW_ITEM,   3'd0, '{8'h03, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'hff, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h80, 1'b1}, 1'b0, '0},
            // unit ends inside a length prefix
            '{ROW_PREFIX, 3'd2, '0,             1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h00, 1'b1}, 1'b1,
              '{8'h00, 1'b0, 1'b1, lpsc_pkg::ST_TRUNC}},
            // zero length first, then the final byte is dropped: first error stays
            '{ROW_PREFIX, 3'd1, '0,             1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h00, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h05, 1'b1}, 1'b1,
              '{8'h00, 1'b0, 1'b1, lpsc_pkg::ST_ZERO}},
            // register 0 acts as a one-byte prefix
            '{ROW_PREFIX, 3'd0, '0,             1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h00, 1'b1}, 1'b1,
              '{8'h00, 1'b0, 1'b1, lpsc_pkg::ST_ZERO}},
            // register 7 acts as four bytes; largest length, cut after one byte
            '{ROW_PREFIX, 3'd7, '0,             1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'hff, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'hff, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'hff, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'hff, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h55, 1'b1}, 1'b0, '0},
            // size shrinks from 4 to 3 after two length bytes of a unit
            '{ROW_PREFIX, 3'd4, '0,             1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h00, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h00, 1'b0}, 1'b0, '0},
            '{ROW_PREFIX, 3'd3, '0,             1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h01, 1'b0}, 1'b0, '0},
            '{ROW_ITEM,   3'd0, '{8'h7e, 1'b1}, 1'b0, '0}
        };

        cfg_prefix = lpsc_pkg::PREFIX_RESET;
        clear_unit();

        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows run under the first idle mix
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_PREFIX)
            begin
                wait_quiet();
                write_prefix(directed_rows[r].prefix);
            end
            else
                send_item(directed_rows[r].item, directed_rows[r].typed,
                          directed_rows[r].want);
        end

        // Random units: three idle mixes, three prefix settings each.
        // Phases end on a unit boundary so the register changes between units.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 38;
                recv_idle_pct = 56;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 38;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_quiet();
            write_prefix(phase_prefix[ph]);
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                build_unit();
                foreach (unit_bytes[i])
                    send_item(unit_bytes[i], 1'b0, '0);
                sent += unit_bytes.size();
            end
        end

        wait_quiet();
        if (annexb_due.size() != 0)
        begin
            $error("%0d expected results never arrived", annexb_due.size());
            mismatch_count++;
        end

        $display("covered %0d input bytes, %0d output transfers, %0d access units (%0d failed)",
                 bytes_in, results_out, units_seen, units_bad);
        $display("prefix register swept 0..7 under three idle mixes, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("length_prefixed_to_start_code_nal_top_test: PASS");
        else
            $display("length_prefixed_to_start_code_nal_top_test: FAIL");
        $finish;
    end

endmodule
